// ===== hw/rtl/bvle_pkg.sv =====
// Shared definitions for the bounded value list engine.
// Holds operation codes, register indexes and the result item type.
// No dependencies.
`default_nettype none
package bvle_pkg;

    localparam int DataW = 32;
    localparam int CountW = 5;
    localparam int MaxResults = 16;

    localparam logic [2:0] OpAppend = 3'd0;
    localparam logic [2:0] OpRemove = 3'd1;
    localparam logic [2:0] OpRemoveAll = 3'd2;
    localparam logic [2:0] OpInsert = 3'd3;
    localparam logic [2:0] OpOrdered = 3'd4;
    localparam logic [2:0] OpDump = 3'd5;

    localparam logic RegCapacity = 1'b0;
    localparam logic [CountW-1:0] CapReset = 5'd16;

    typedef struct packed {
        logic ok;
        logic [CountW-1:0] count;
        logic signed [DataW-1:0] entry;
        logic entry_valid;
        logic last;
    } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bvle_ram.sv =====
// Entry storage for the bounded value list engine.
// One write port and one registered read port; uses bvle_pkg.
`default_nettype none
module bvle_ram #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [bvle_pkg::DataW-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr,
    output logic [bvle_pkg::DataW-1:0]      rdata
);

    logic [bvle_pkg::DataW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bvle_ctrl.sv =====
// Sequencer of the bounded value list engine: walks the entry memory one
// entry at a time through a single compare unit and holds the result register.
// Uses bvle_pkg; drives the ports of bvle_ram.
`default_nettype none
module bvle_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [2:0]                       op,
    input  wire logic signed [bvle_pkg::DataW-1:0] value,
    input  wire logic signed [bvle_pkg::DataW-1:0] anchor,
    input  wire logic [bvle_pkg::CountW-1:0]      capacity,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output bvle_pkg::res_t                        res,
    output logic                                  mem_we,
    output logic [AW-1:0]                         mem_waddr,
    output logic [bvle_pkg::DataW-1:0]            mem_wdata,
    output logic                                  mem_re,
    output logic [AW-1:0]                         mem_raddr,
    input  wire logic [bvle_pkg::DataW-1:0]       mem_rdata
);

    localparam int UW = $clog2(DEPTH + 1);
    localparam int CW = (UW > bvle_pkg::CountW) ? UW : bvle_pkg::CountW;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_SCAN_RD   = 11'b000_0000_0010,
        S_SCAN_CMP  = 11'b000_0000_0100,
        S_LAST_RD   = 11'b000_0000_1000,
        S_LAST_WR   = 11'b000_0001_0000,
        S_SHIFT_RD  = 11'b000_0010_0000,
        S_SHIFT_WR  = 11'b000_0100_0000,
        S_INS_WR    = 11'b000_1000_0000,
        S_DUMP_RD   = 11'b001_0000_0000,
        S_DUMP_EMIT = 11'b010_0000_0000,
        S_RESULT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [bvle_pkg::DataW-1:0] key_reg, key_next;
    logic [bvle_pkg::DataW-1:0] val_reg, val_next;
    logic [UW-1:0] i_reg, i_next;
    logic [UW-1:0] j_reg, j_next;
    logic [UW-1:0] n_reg, n_next;
    logic [UW-1:0] used_reg, used_next;
    logic ok_reg, ok_next;
    logic out_valid_reg, out_valid_next;
    bvle_pkg::res_t res_reg, res_next;

    logic [UW-1:0] eff_cap;
    logic full;
    logic out_free;
    logic match;
    logic [UW-1:0] i_plus;
    logic [UW-1:0] j_dec;
    logic [UW-1:0] used_dec;
    logic load_out;

    always_comb
    begin
        if (capacity == '0 || CW'(capacity) > CW'(DEPTH))
        begin
            eff_cap = UW'(DEPTH);
        end
        else
        begin
            eff_cap = UW'(capacity);
        end
    end

    assign full = (used_reg >= eff_cap);
    assign out_free = !out_valid_reg || !out_stall;
    assign match = (mem_rdata == key_reg);
    assign i_plus = i_reg + 1'b1;
    assign j_dec = j_reg - 1'b1;
    assign used_dec = used_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        i_next = i_reg;
        j_next = j_reg;
        n_next = n_reg;
        used_next = used_reg;
        ok_next = ok_reg;
        res_next = res_reg;
        load_out = 1'b0;
        mem_we = 1'b0;
        mem_waddr = i_reg[AW-1:0];
        mem_wdata = mem_rdata;
        mem_re = 1'b0;
        mem_raddr = i_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    i_next = '0;
                    j_next = '0;
                    ok_next = 1'b0;
                    key_next = value;
                    val_next = value;
                    case (op)
                        bvle_pkg::OpAppend:
                        begin
                            if (!full)
                            begin
                                mem_we = 1'b1;
                                mem_waddr = used_reg[AW-1:0];
                                mem_wdata = value;
                                used_next = used_reg + 1'b1;
                                ok_next = 1'b1;
                            end
                            state_next = S_RESULT;
                        end
                        bvle_pkg::OpRemove, bvle_pkg::OpRemoveAll, bvle_pkg::OpOrdered:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        bvle_pkg::OpInsert:
                        begin
                            key_next = anchor;
                            state_next = S_SCAN_RD;
                        end
                        bvle_pkg::OpDump:
                        begin
                            if (CW'(used_reg) > CW'(bvle_pkg::MaxResults))
                            begin
                                n_next = UW'(bvle_pkg::MaxResults);
                            end
                            else
                            begin
                                n_next = used_reg;
                            end
                            if (used_reg == '0)
                            begin
                                ok_next = 1'b1;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (i_reg < used_reg)
                begin
                    mem_re = 1'b1;
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    if (op_reg == bvle_pkg::OpOrdered)
                    begin
                        used_next = j_reg;
                    end
                    state_next = S_RESULT;
                end
            end
            S_SCAN_CMP:
            begin
                case (op_reg)
                    bvle_pkg::OpRemove, bvle_pkg::OpRemoveAll:
                    begin
                        if (match)
                        begin
                            ok_next = 1'b1;
                            state_next = S_LAST_RD;
                        end
                        else
                        begin
                            i_next = i_plus;
                            state_next = S_SCAN_RD;
                        end
                    end
                    bvle_pkg::OpInsert:
                    begin
                        if (match)
                        begin
                            j_next = used_reg;
                            state_next = full ? S_RESULT : S_SHIFT_RD;
                        end
                        else
                        begin
                            i_next = i_plus;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        if (match)
                        begin
                            ok_next = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_waddr = j_reg[AW-1:0];
                            j_next = j_reg + 1'b1;
                        end
                        i_next = i_plus;
                        state_next = S_SCAN_RD;
                    end
                endcase
            end
            S_LAST_RD:
            begin
                mem_re = 1'b1;
                mem_raddr = used_dec[AW-1:0];
                state_next = S_LAST_WR;
            end
            S_LAST_WR:
            begin
                mem_we = 1'b1;
                used_next = used_dec;
                state_next = (op_reg == bvle_pkg::OpRemoveAll) ? S_SCAN_RD : S_RESULT;
            end
            S_SHIFT_RD:
            begin
                if (j_reg > i_plus)
                begin
                    mem_re = 1'b1;
                    mem_raddr = j_dec[AW-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                j_next = j_dec;
                state_next = S_SHIFT_RD;
            end
            S_INS_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = i_plus[AW-1:0];
                mem_wdata = val_reg;
                used_next = used_reg + 1'b1;
                ok_next = 1'b1;
                state_next = S_RESULT;
            end
            S_DUMP_RD:
            begin
                mem_re = 1'b1;
                state_next = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    res_next.ok = 1'b1;
                    res_next.count = bvle_pkg::CountW'(used_reg);
                    res_next.entry = mem_rdata;
                    res_next.entry_valid = 1'b1;
                    res_next.last = (i_plus == n_reg);
                    i_next = i_plus;
                    state_next = (i_plus == n_reg) ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    res_next.ok = ok_reg;
                    res_next.count = bvle_pkg::CountW'(used_reg);
                    res_next.entry = '0;
                    res_next.entry_valid = 1'b0;
                    res_next.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        i_reg <= i_next;
        j_reg <= j_next;
        n_reg <= n_next;
        ok_reg <= ok_next;
        res_reg <= res_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign res = res_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_value_list_engine_unit.sv =====
// An item that needs no search (append, unknown operation, empty dump) goes
// straight to its result; any other item is paced by the entry memory,
// whose registered read sets the pace: a search reads the list
// once, a swap removal adds one read of the last entry, an insert adds one read
// per entry shifted up, and a dump reads each entry before it emits it and
// waits while the output register is stalled. No item is taken until the
// previous one has its result in the output register; that register lets the
// next item in while the last result still waits to be taken.
// Top level: capacity register on the APB port, bvle_ctrl and bvle_ram.
`default_nettype none
module bounded_value_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [2:0]                        op,
    input  wire logic signed [bvle_pkg::DataW-1:0] value,
    input  wire logic signed [bvle_pkg::DataW-1:0] anchor,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   ok,
    output logic [bvle_pkg::CountW-1:0]            count,
    output logic signed [bvle_pkg::DataW-1:0]      entry,
    output logic                                   entry_valid,
    output logic                                   last
);

    localparam int AW = $clog2(DEPTH);

    logic [bvle_pkg::CountW-1:0] cap_reg;
    logic cfg_wr;
    bvle_pkg::res_t res;
    logic mem_we;
    logic mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [bvle_pkg::DataW-1:0] mem_wdata;
    logic [bvle_pkg::DataW-1:0] mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bvle_pkg::RegCapacity);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bvle_pkg::CapReset;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[bvle_pkg::CountW-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == bvle_pkg::RegCapacity)
        begin
            prdata = 32'(cap_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    bvle_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .value(value),
        .anchor(anchor),
        .capacity(cap_reg),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .res(res),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re(mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    bvle_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign ok = res.ok;
    assign count = res.count;
    assign entry = res.entry;
    assign entry_valid = res.entry_valid;
    assign last = res.last;

endmodule
`default_nettype wire

// ===== hw/rtl/bvle_checker.sv =====
// Port-level checks for the bounded value list engine, bound to the top level.
// Depends on bounded_value_list_engine_unit and bvle_pkg.
`default_nettype none
module bvle_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              ok,
    input wire logic [bvle_pkg::CountW-1:0]       count,
    input wire logic signed [bvle_pkg::DataW-1:0] entry,
    input wire logic                              entry_valid,
    input wire logic                              last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) && $stable(count)
            && $stable(entry) && $stable(entry_valid) && $stable(last))
        else $error("Stalled result item changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input taken again before the previous item finished.");

    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> last && (entry == '0))
        else $error("Result without an entry must be a single zero item.");

    a_dump_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> ok)
        else $error("Dumped entry must report ok.");

endmodule

bind bounded_value_list_engine_unit bvle_checker u_bvle_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok(ok),
    .count(count),
    .entry(entry),
    .entry_valid(entry_valid),
    .last(last)
);
`default_nettype wire

// ===== verif/bvle_list_checker.sv =====
// Checker for bounded_value_list_engine_unit: follows the capacity register writes and
// the input and result channels, keeps its own copy of the list, and compares every result.
// Depends on bvle_pkg.
module bvle_list_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    input  logic                                 pready,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [2:0]                           op,
    input  logic signed [bvle_pkg::DataW-1:0]    value,
    input  logic signed [bvle_pkg::DataW-1:0]    anchor,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 ok,
    input  logic [bvle_pkg::CountW-1:0]          count,
    input  logic signed [bvle_pkg::DataW-1:0]    entry,
    input  logic                                 entry_valid,
    input  logic                                 last,
    output int                                   failures,
    output int                                   results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CapAddr = {bvle_pkg::RegCapacity, 2'b00};

    logic signed [bvle_pkg::DataW-1:0] list_vals [DEPTH];
    int                                list_len;
    logic [bvle_pkg::CountW-1:0]       cap_reg;
    bvle_pkg::res_t                    pending_results [$];
    int                                mismatches = 0;

    assign failures = mismatches;

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic apply_list_op(input logic [2:0] code,
                                 input logic signed [bvle_pkg::DataW-1:0] v,
                                 input logic signed [bvle_pkg::DataW-1:0] a);
        int             i;
        int             j;
        int             room;
        int             n;
        logic           hit;
        bvle_pkg::res_t r;
        hit = 1'b0;
        room = (cap_reg == '0 || cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        r = '0;
        r.ok = 1'b1;
        r.last = 1'b1;
        if (code == bvle_pkg::OpDump)
        begin
            n = (list_len > bvle_pkg::MaxResults) ? bvle_pkg::MaxResults : list_len;
            r.count = bvle_pkg::CountW'(list_len);
            if (n == 0)
                pending_results.push_back(r);
            for (i = 0; i < n; i++)
            begin
                r.entry = list_vals[i];
                r.entry_valid = 1'b1;
                r.last = (i == n - 1);
                pending_results.push_back(r);
            end
        end
        else
        begin
            case (code)
                bvle_pkg::OpAppend:
                begin
                    if (list_len < room)
                    begin
                        list_vals[list_len] = v;
                        list_len++;
                        hit = 1'b1;
                    end
                end
                bvle_pkg::OpRemove:
                begin
                    i = 0;
                    while (i < list_len && list_vals[i] != v)
                        i++;
                    if (i < list_len)
                    begin
                        list_vals[i] = list_vals[list_len - 1];
                        list_len--;
                        hit = 1'b1;
                    end
                end
                bvle_pkg::OpRemoveAll:
                begin
                    i = 0;
                    while (i < list_len)
                    begin
                        if (list_vals[i] == v)
                        begin
                            list_vals[i] = list_vals[list_len - 1];
                            list_len--;
                            hit = 1'b1;
                        end
                        else
                            i++;
                    end
                end
                bvle_pkg::OpInsert:
                begin
                    i = 0;
                    while (i < list_len && list_vals[i] != a)
                        i++;
                    if (i < list_len && list_len < room)
                    begin
                        for (j = list_len; j > i + 1; j--)
                            list_vals[j] = list_vals[j - 1];
                        list_vals[i + 1] = v;
                        list_len++;
                        hit = 1'b1;
                    end
                end
                bvle_pkg::OpOrdered:
                begin
                    j = 0;
                    for (i = 0; i < list_len; i++)
                    begin
                        if (list_vals[i] == v)
                            hit = 1'b1;
                        else
                        begin
                            list_vals[j] = list_vals[i];
                            j++;
                        end
                    end
                    list_len = j;
                end
                default:
                begin
                end
            endcase
            r.ok = hit;
            r.count = bvle_pkg::CountW'(list_len);
            pending_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bvle_pkg::res_t got;
        bvle_pkg::res_t want;
        if (!rst_n)
        begin
            list_len = 0;
            cap_reg = bvle_pkg::CapReset;
            pending_results.delete();
            results_owed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.ok = ok;
                got.count = count;
                got.entry = entry;
                got.entry_valid = entry_valid;
                got.last = last;
                if (pending_results.size() == 0)
                begin
                    $error("Result item with no item waiting: count %0d, entry %0d", count, entry);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("ok", longint'(want.ok), longint'(got.ok));
                    compare_field("count", longint'(want.count), longint'(got.count));
                    compare_field("entry", longint'(want.entry), longint'(got.entry));
                    compare_field("entry_valid", longint'(want.entry_valid),
                                  longint'(got.entry_valid));
                    compare_field("last", longint'(want.last), longint'(got.last));
                end
            end
            if (psel && penable && pwrite && pready && paddr == CapAddr)
                cap_reg = pwdata[bvle_pkg::CountW-1:0];
            if (in_valid && !in_stall)
                apply_list_op(op, value, anchor);
            results_owed = pending_results.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Top-level testbench for bounded_value_list_engine_unit: clock, reset, capacity writes,
// directed and random item stimulus with random idling, and the final verdict.
// Depends on bvle_pkg, the block itself and bvle_list_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 16;
    localparam int SettleCycles = 4 * Depth + 16;
    localparam int CycleLimit = 500000;
    localparam int Phases = 10;
    localparam int PhaseItems = 50;
    localparam logic [2:0] OpSpare6 = 3'd6;
    localparam logic [2:0] OpSpare7 = 3'd7;
    localparam logic [2:0] CapAddr = {bvle_pkg::RegCapacity, 2'b00};
    localparam logic signed [bvle_pkg::DataW-1:0] MinVal = 32'h8000_0000;
    localparam logic signed [bvle_pkg::DataW-1:0] MaxVal = 32'h7fff_ffff;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [2:0]                         paddr;
    logic [31:0]                        pwdata;
    logic [31:0]                        prdata;
    logic                               pready;
    logic                               in_valid;
    logic                               in_stall;
    logic [2:0]                         op;
    logic signed [bvle_pkg::DataW-1:0]  value;
    logic signed [bvle_pkg::DataW-1:0]  anchor;
    logic                               out_valid;
    logic                               out_stall;
    logic                               ok;
    logic [bvle_pkg::CountW-1:0]        count;
    logic signed [bvle_pkg::DataW-1:0]  entry;
    logic                               entry_valid;
    logic                               last;
    int                                 failures;
    int                                 results_owed;
    logic                               idle_mode;
    int                                 cycles = 0;
    logic signed [bvle_pkg::DataW-1:0]  value_pool [8];
    logic [bvle_pkg::CountW-1:0]        phase_caps [Phases] =
        '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd2, 5'd16};

    bounded_value_list_engine_unit #(
        .DEPTH(Depth)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .value(value),
        .anchor(anchor),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ok(ok),
        .count(count),
        .entry(entry),
        .entry_valid(entry_valid),
        .last(last)
    );

    bvle_list_checker #(
        .DEPTH(Depth)
    ) list_check (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .value(value),
        .anchor(anchor),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ok(ok),
        .count(count),
        .entry(entry),
        .entry_valid(entry_valid),
        .last(last),
        .failures(failures),
        .results_owed(results_owed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_mode && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [bvle_pkg::DataW-1:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [2:0] pick_op(input int fill_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < fill_pct)
            return bvle_pkg::OpAppend;
        r = $urandom_range(0, 99);
        if (r < 20)
            return bvle_pkg::OpRemove;
        if (r < 35)
            return bvle_pkg::OpRemoveAll;
        if (r < 65)
            return bvle_pkg::OpInsert;
        if (r < 78)
            return bvle_pkg::OpOrdered;
        if (r < 94)
            return bvle_pkg::OpDump;
        return r[0] ? OpSpare6 : OpSpare7;
    endfunction

    task automatic refresh_pool();
        int i;
        value_pool[0] = MinVal;
        value_pool[1] = MaxVal;
        value_pool[2] = '0;
        value_pool[3] = '1;
        for (i = 4; i < 8; i++)
            value_pool[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
    endtask

    task automatic send_item(input logic [2:0] code,
                             input logic signed [bvle_pkg::DataW-1:0] v,
                             input logic signed [bvle_pkg::DataW-1:0] a);
        int gap;
        @(negedge clk);
        if (idle_mode && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        value <= v;
        anchor <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [bvle_pkg::CountW-1:0] cap);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CapAddr;
        pwdata <= {{(32 - bvle_pkg::CountW){1'b0}}, cap};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin : stimulus
        int ph;
        int k;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = CapAddr;
        pwdata = '0;
        in_valid = 1'b0;
        op = bvle_pkg::OpAppend;
        value = '0;
        anchor = '0;
        idle_mode = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        idle_mode <= 1'b1;
        refresh_pool();

        send_item(bvle_pkg::OpDump, 0, 0);
        send_item(bvle_pkg::OpRemove, 0, 0);
        send_item(bvle_pkg::OpInsert, 5, 0);
        send_item(bvle_pkg::OpAppend, MinVal, 0);
        send_item(bvle_pkg::OpAppend, MaxVal, 0);
        send_item(bvle_pkg::OpAppend, 0, 0);
        send_item(bvle_pkg::OpAppend, -1, 0);
        send_item(bvle_pkg::OpAppend, MinVal, 0);
        send_item(bvle_pkg::OpInsert, 5, MaxVal);
        send_item(bvle_pkg::OpInsert, 6, 12345);
        send_item(bvle_pkg::OpAppend, 7, 0);
        send_item(bvle_pkg::OpAppend, 7, 0);
        send_item(bvle_pkg::OpRemoveAll, 7, 0);
        send_item(bvle_pkg::OpRemove, MinVal, 0);
        send_item(bvle_pkg::OpOrdered, MinVal, 0);
        send_item(OpSpare6, 0, 0);
        send_item(OpSpare7, 0, 0);
        send_item(bvle_pkg::OpDump, 0, 0);
        // The list now holds more entries than the new capacity allows.
        wait_idle();
        write_capacity(5'd2);
        send_item(bvle_pkg::OpAppend, 1, 0);
        send_item(bvle_pkg::OpInsert, 1, 0);
        send_item(bvle_pkg::OpOrdered, -1, 0);
        send_item(bvle_pkg::OpDump, 0, 0);
        wait_idle();
        write_capacity(5'd0);
        send_item(bvle_pkg::OpAppend, 9, 0);
        wait_idle();
        write_capacity(5'd31);
        send_item(bvle_pkg::OpAppend, 10, 0);
        send_item(bvle_pkg::OpDump, 0, 0);

        for (ph = 0; ph < Phases; ph++)
        begin
            wait_idle();
            write_capacity((ph == 7) ? bvle_pkg::CountW'($urandom_range(0, 31))
                                     : phase_caps[ph]);
            refresh_pool();
            idle_mode <= (ph < Phases - 2) && (ph != 3);
            for (k = 0; k < PhaseItems; k++)
                send_item(pick_op(ph[0] ? 25 : 60), pick_value(), pick_value());
        end

        wait_idle();
        if (failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bvle_pkg.sv
hw/rtl/bvle_ram.sv
hw/rtl/bvle_ctrl.sv
hw/rtl/bounded_value_list_engine_unit.sv
hw/rtl/bvle_checker.sv
verif/bvle_list_checker.sv
verif/tb.sv
